// ===== hw/rtl/rpl_pkg.sv =====
`timescale 1ns / 1ps

package rpl_pkg;

    // Default sizes of the seen-token store.
    localparam int DEF_SLOTS       = 16;
    localparam int DEF_VOCAB_SLICE = 65536;
    localparam int DEF_TOKEN_BITS  = 20;

    // Field widths of the beats.
    localparam int OP_W      = 2;
    localparam int SLOT_W    = 4;
    localparam int TOKEN_W   = 20;
    localparam int LIDX_W    = 16;
    localparam int LOGIT_W   = 32;
    localparam int GAIN_W    = 16;
    localparam int SIZE_W    = 17;
    localparam int PROD_W    = LOGIT_W + GAIN_W;
    localparam int FRAC_W    = 12;

    localparam int IN_TDATA_W  = SLOT_W + TOKEN_W + LIDX_W + LOGIT_W;
    localparam int IN_TUSER_W  = OP_W;
    localparam int OUT_TDATA_W = LOGIT_W;
    localparam int OUT_TUSER_W = 2;

    // Configuration channel.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Range compares on token ids, offsets and limits fit in this width.
    localparam int CMP_W = 21;

    // Words of 64 seen bits.
    localparam int WORD_W    = 64;
    localparam int BIT_IDX_W = 6;

    // Output queue.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // Configuration reset values.
    localparam logic [GAIN_W-1:0]  RST_PENALTY_GAIN = 16'd4096;
    localparam logic [GAIN_W-1:0]  RST_INVERSE_GAIN = 16'd4096;
    localparam logic [TOKEN_W-1:0] RST_SHARD_OFFSET = 20'd0;
    localparam logic [SIZE_W-1:0]  RST_SHARD_SIZE   = 17'd65536;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR    = 2'd0,
        OP_MARK     = 2'd1,
        OP_PENALIZE = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PENALTY_GAIN = 3'd0,
        REG_INVERSE_GAIN = 3'd1,
        REG_SHARD_OFFSET = 3'd2,
        REG_SHARD_SIZE   = 3'd3,
        REG_SHARDED_MODE = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic                      saturated;
        logic                      was_penalized;
        logic signed [LOGIT_W-1:0] logit_out;
    } result_t;

    // One penalize item entering the scaling stage.
    typedef struct packed {
        logic                seen;
        logic                neg;
        logic [LOGIT_W-1:0]  mag;
        logic [GAIN_W-1:0]   gain;
        logic [LOGIT_W-1:0]  logit;
    } scale_req_t;

endpackage

// ===== hw/rtl/rpl_ram.sv =====
`timescale 1ns / 1ps

module rpl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/rpl_scaler.sv =====
`timescale 1ns / 1ps

module rpl_scaler (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  rpl_pkg::scale_req_t in_req,
    output logic                out_valid,
    output rpl_pkg::result_t    out_result
);

    import rpl_pkg::*;

    logic                 valid_reg;
    logic                 seen_reg;
    logic                 neg_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [LOGIT_W-1:0]   logit_reg;
    logic [PROD_W-1:0]    prod_next;

    logic [PROD_W:0]          rounded;
    logic [PROD_W-FRAC_W:0]   quot;
    logic [LOGIT_W-1:0]       clipped;
    logic                     sat;

    assign prod_next = PROD_W'(in_req.mag) * PROD_W'(in_req.gain);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            seen_reg  <= in_req.seen;
            neg_reg   <= in_req.neg;
            prod_reg  <= prod_next;
            logit_reg <= in_req.logit;
        end
    end

    // Round to nearest at 12 fractional bits; the magnitude makes ties go away from zero.
    always_comb
    begin
        rounded = {1'b0, prod_reg} + (PROD_W + 1)'(1 << (FRAC_W - 1));
        quot    = rounded[PROD_W:FRAC_W];
        sat     = 1'b0;
        clipped = quot[LOGIT_W-1:0];
        if (neg_reg)
        begin
            if (quot > (PROD_W - FRAC_W + 1)'(33'h1_0000_0000 >> 1))
            begin
                sat     = 1'b1;
                clipped = 32'h8000_0000;
            end
            clipped = ~clipped + 32'd1;
        end
        else if (quot > (PROD_W - FRAC_W + 1)'(32'h7FFF_FFFF))
        begin
            sat     = 1'b1;
            clipped = 32'h7FFF_FFFF;
        end
    end

    always_comb
    begin
        out_valid = valid_reg;
        if (seen_reg)
        begin
            out_result.logit_out     = clipped;
            out_result.was_penalized = 1'b1;
            out_result.saturated     = sat;
        end
        else
        begin
            out_result.logit_out     = logit_reg;
            out_result.was_penalized = 1'b0;
            out_result.saturated     = 1'b0;
        end
    end

endmodule

// ===== hw/rtl/repetition_penalty_logits_top.sv =====
`timescale 1ns / 1ps
// A penalize beat's result is offered on the master side after the seen-bit read,
// the multiply with round and saturate, and the output queue.
// Throughput: one mark or penalize item per cycle while no sweep runs and the output
// queue has room; a slot clear holds the input while the slot's words are zeroed.
// Reset: control state clears at once, then a clearing pass zeroes all
// SLOTS*VOCAB_SLICE/64 words with s_axis_tready low.
module repetition_penalty_logits_top
    import rpl_pkg::DEF_SLOTS, rpl_pkg::DEF_VOCAB_SLICE, rpl_pkg::DEF_TOKEN_BITS;
#(
    parameter int SLOTS       = DEF_SLOTS,
    parameter int VOCAB_SLICE = DEF_VOCAB_SLICE,
    parameter int TOKEN_BITS  = DEF_TOKEN_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input beat. tdata: slot, token_id, logit_index, logit_in. tuser: operation.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [rpl_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic [rpl_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    // Result beat. tdata: logit_out. tuser: was_penalized, saturated.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [rpl_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic [rpl_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
    // Register writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rpl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rpl_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import rpl_pkg::*;

    localparam int WPS   = (VOCAB_SLICE + 63) / 64;
    localparam int DEPTH = SLOTS * WPS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW    = (WPS > 1) ? $clog2(WPS) : 1;

    localparam logic [TOKEN_W-1:0] TOKEN_MASK = (TOKEN_BITS >= TOKEN_W) ? {TOKEN_W{1'b1}} :
                                                TOKEN_W'((64'd1 << TOKEN_BITS) - 64'd1);
    localparam logic [CMP_W-1:0]   SLICE_LIM  = CMP_W'(VOCAB_SLICE);

    // Configuration registers.
    logic [GAIN_W-1:0]  penalty_gain_reg;
    logic [GAIN_W-1:0]  inverse_gain_reg;
    logic [TOKEN_W-1:0] shard_offset_reg;
    logic [SIZE_W-1:0]  shard_size_reg;
    logic               sharded_mode_reg;

    // Input fields.
    logic [OP_W-1:0]    in_op;
    logic [SLOT_W-1:0]  in_slot;
    logic [TOKEN_W-1:0] in_token;
    logic [LIDX_W-1:0]  in_lidx;
    logic [LOGIT_W-1:0] in_logit;

    // Front-end decode.
    logic               accept;
    logic               slot_ok;
    logic [CMP_W-1:0]   limit;
    logic [CMP_W-1:0]   tok_ext;
    logic [CMP_W-1:0]   off_ext;
    logic [CMP_W-1:0]   idx;
    logic               in_range;
    logic [AW-1:0]      base_addr;
    logic [AW-1:0]      rd_addr;
    logic               is_mark;
    logic               is_pen;
    logic               ram_re;

    // Stage one: memory data returns.
    logic               s1_valid_reg;
    logic               s1_mark_reg;
    logic               s1_range_reg;
    logic [AW-1:0]      s1_addr_reg;
    logic [BIT_IDX_W-1:0] s1_bit_reg;
    logic               s1_neg_reg;
    logic [LOGIT_W-1:0] s1_mag_reg;
    logic [GAIN_W-1:0]  s1_gain_reg;
    logic [LOGIT_W-1:0] s1_logit_reg;

    logic               fwd_hit_reg;
    logic [WORD_W-1:0]  fwd_data_reg;
    logic               fwd_hit_next;

    logic [WORD_W-1:0]  ram_rdata;
    logic [WORD_W-1:0]  cur_word;
    logic [WORD_W-1:0]  marked_word;
    logic               mark_we;
    logic               seen;
    logic               pen_valid;
    scale_req_t         pen_req;

    // Clearing sweep.
    logic               sweep_busy_reg;
    logic               sweep_busy_next;
    logic [AW-1:0]      sweep_addr_reg;
    logic [AW-1:0]      sweep_addr_next;
    logic [AW-1:0]      sweep_end_reg;
    logic [AW-1:0]      sweep_end_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;

    // Result path.
    logic               sc_valid;
    result_t            sc_result;
    result_t            fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic [FIFO_CNT_W-1:0] pending;
    logic               pop;

    assign in_slot  = s_axis_tdata[SLOT_W-1:0];
    assign in_token = s_axis_tdata[SLOT_W +: TOKEN_W];
    assign in_lidx  = s_axis_tdata[SLOT_W + TOKEN_W +: LIDX_W];
    assign in_logit = s_axis_tdata[SLOT_W + TOKEN_W + LIDX_W +: LOGIT_W];
    assign in_op    = s_axis_tuser;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            penalty_gain_reg <= RST_PENALTY_GAIN;
            inverse_gain_reg <= RST_INVERSE_GAIN;
            shard_offset_reg <= RST_SHARD_OFFSET;
            shard_size_reg   <= RST_SHARD_SIZE;
            sharded_mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PENALTY_GAIN: penalty_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_INVERSE_GAIN: inverse_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_SHARD_OFFSET: shard_offset_reg <= cfg_data[TOKEN_W-1:0];
                REG_SHARD_SIZE:   shard_size_reg   <= cfg_data[SIZE_W-1:0];
                REG_SHARDED_MODE: sharded_mode_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Decode and memory read
    // ------------------------------------------------------------------
    assign pending       = count_reg + FIFO_CNT_W'(s1_valid_reg & ~s1_mark_reg)
                         + FIFO_CNT_W'(sc_valid);
    assign s_axis_tready = !sweep_busy_reg && (pending < FIFO_CNT_W'(FIFO_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        is_mark = (in_op == OP_MARK);
        is_pen  = (in_op == OP_PENALIZE);
        slot_ok = (int'(in_slot) < SLOTS);
        limit   = (CMP_W'(shard_size_reg) > SLICE_LIM) ? SLICE_LIM : CMP_W'(shard_size_reg);
        tok_ext = CMP_W'(in_token & TOKEN_MASK);
        off_ext = CMP_W'(shard_offset_reg);
        if (is_pen)
        begin
            idx      = CMP_W'(in_lidx);
            in_range = slot_ok && (idx < limit);
        end
        else if (sharded_mode_reg)
        begin
            idx      = tok_ext - off_ext;
            in_range = slot_ok && (tok_ext >= off_ext) && (tok_ext < off_ext + limit);
        end
        else
        begin
            idx      = tok_ext;
            in_range = slot_ok && (tok_ext < limit);
        end
        base_addr = AW'(in_slot) * AW'(WPS);
        rd_addr   = base_addr + AW'(idx[BIT_IDX_W +: WW]);
        ram_re    = accept && (is_mark || is_pen) && in_range;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && (is_mark || is_pen);
            fwd_hit_reg  <= fwd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mark_reg  <= is_mark;
            s1_range_reg <= in_range;
            s1_addr_reg  <= rd_addr;
            s1_bit_reg   <= idx[BIT_IDX_W-1:0];
            s1_neg_reg   <= in_logit[LOGIT_W-1];
            s1_mag_reg   <= in_logit[LOGIT_W-1] ? (~in_logit + 32'd1) : in_logit;
            s1_gain_reg  <= in_logit[LOGIT_W-1] ? penalty_gain_reg : inverse_gain_reg;
            s1_logit_reg <= in_logit;
        end
        fwd_data_reg <= marked_word;
    end

    // ------------------------------------------------------------------
    // Read-modify-write of the seen word
    // ------------------------------------------------------------------
    // A mark writes back in the cycle its word returns; the item read at that
    // same edge sees the old word, so the new one is forwarded to it.
    always_comb
    begin
        cur_word     = fwd_hit_reg ? fwd_data_reg : ram_rdata;
        marked_word  = cur_word | (WORD_W'(1) << s1_bit_reg);
        mark_we      = s1_valid_reg && s1_mark_reg && s1_range_reg;
        fwd_hit_next = ram_re && mark_we && (rd_addr == s1_addr_reg);
        seen         = s1_range_reg && cur_word[s1_bit_reg];
        pen_valid    = s1_valid_reg && !s1_mark_reg;
        pen_req.seen  = seen;
        pen_req.neg   = s1_neg_reg;
        pen_req.mag   = s1_mag_reg;
        pen_req.gain  = s1_gain_reg;
        pen_req.logit = s1_logit_reg;
    end

    // ------------------------------------------------------------------
    // Clearing sweep: whole memory after reset, one slot per clear beat.
    // ------------------------------------------------------------------
    always_comb
    begin
        sweep_busy_next = sweep_busy_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_end_next  = sweep_end_reg;
        if (sweep_busy_reg)
        begin
            if (sweep_addr_reg == sweep_end_reg)
            begin
                sweep_busy_next = 1'b0;
            end
            else
            begin
                sweep_addr_next = sweep_addr_reg + AW'(1);
            end
        end
        else if (accept && (in_op == OP_CLEAR) && slot_ok)
        begin
            sweep_busy_next = 1'b1;
            sweep_addr_next = base_addr;
            sweep_end_next  = base_addr + AW'(WPS - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_busy_reg <= 1'b1;
            sweep_addr_reg <= '0;
            sweep_end_reg  <= AW'(DEPTH - 1);
        end
        else
        begin
            sweep_busy_reg <= sweep_busy_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_end_reg  <= sweep_end_next;
        end
    end

    // Sweep and mark writes never fall in the same cycle: the input is held
    // during a sweep, and the clear beat itself leaves stage one empty.
    always_comb
    begin
        ram_we    = sweep_busy_reg || mark_we;
        ram_waddr = sweep_busy_reg ? sweep_addr_reg : s1_addr_reg;
        ram_wdata = sweep_busy_reg ? '0 : marked_word;
    end

    rpl_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_seen_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Scaling and output queue
    // ------------------------------------------------------------------
    rpl_scaler u_scaler (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (pen_valid),
        .in_req     (pen_req),
        .out_valid  (sc_valid),
        .out_result (sc_result)
    );

    assign pop        = m_axis_tvalid && m_axis_tready;
    assign count_next = count_reg + FIFO_CNT_W'(sc_valid) - FIFO_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (sc_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sc_valid)
        begin
            fifo_mem_reg[wr_ptr_reg] <= sc_result;
        end
    end

    always_comb
    begin
        m_axis_tvalid   = (count_reg != '0);
        m_axis_tdata    = fifo_mem_reg[rd_ptr_reg].logit_out;
        m_axis_tuser[0] = fifo_mem_reg[rd_ptr_reg].was_penalized;
        m_axis_tuser[1] = fifo_mem_reg[rd_ptr_reg].saturated;
    end

endmodule

// ===== verif/repetition_penalty_logits_top_tb.sv =====
`timescale 1ns / 1ps

module repetition_penalty_logits_top_tb;
    import rpl_pkg::*;

    // The fourth operation code has no function and must be ignored.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int SLICE = DEF_VOCAB_SLICE;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Shadow copy of the seen-token store and the registers.
    bit [SLICE-1:0]     seen_map [DEF_SLOTS];
    logic [GAIN_W-1:0]  penalty_gain_q = RST_PENALTY_GAIN;
    logic [GAIN_W-1:0]  inverse_gain_q = RST_INVERSE_GAIN;
    logic [TOKEN_W-1:0] shard_offset_q = RST_SHARD_OFFSET;
    logic [SIZE_W-1:0]  shard_size_q = RST_SHARD_SIZE;
    logic               sharded_mode_q = 1'b0;

    result_t expected_logits [$];
    int      error_count = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      stall_request = 0;

    repetition_penalty_logits_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned slice_limit();
        if (shard_size_q < SLICE)
            return 64'(shard_size_q);
        return 64'(SLICE);
    endfunction

    // Updates the shadow store for one item and returns 1 with the expected result
    // when the item produces a result beat.
    function automatic bit update_penalty_model(input logic [OP_W-1:0] op,
                                                input logic [SLOT_W-1:0] slot,
                                                input logic [TOKEN_W-1:0] token,
                                                input logic [LIDX_W-1:0] lidx,
                                                input logic [LOGIT_W-1:0] logit,
                                                output result_t res);
        longint unsigned lim;
        logic [63:0]     mag;
        logic [63:0]     q;
        logic            neg;
        lim = slice_limit();
        res = '0;
        case (op)
            OP_CLEAR:
                seen_map[slot] = '0;
            OP_MARK:
            begin
                if (sharded_mode_q)
                begin
                    if (token >= shard_offset_q && token < shard_offset_q + lim)
                        seen_map[slot][token - shard_offset_q] = 1'b1;
                end
                else if (token < lim)
                begin
                    seen_map[slot][token] = 1'b1;
                end
            end
            OP_PENALIZE:
            begin
                res.logit_out = logit;
                if (lidx < lim && seen_map[slot][lidx])
                begin
                    neg = logit[LOGIT_W-1];
                    mag = neg ? {32'd0, ~logit + 32'd1} : {32'd0, logit};
                    // Round half away from zero on the magnitude, then restore the sign.
                    q = (mag * (neg ? penalty_gain_q : inverse_gain_q) + 64'd2048) >> FRAC_W;
                    res.was_penalized = 1'b1;
                    if (neg)
                    begin
                        if (q > 64'h8000_0000)
                        begin
                            q = 64'h8000_0000;
                            res.saturated = 1'b1;
                        end
                        res.logit_out = ~q[31:0] + 32'd1;
                    end
                    else
                    begin
                        if (q > 64'h7FFF_FFFF)
                        begin
                            q = 64'h7FFF_FFFF;
                            res.saturated = 1'b1;
                        end
                        res.logit_out = q[31:0];
                    end
                end
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic logic [LIDX_W-1:0] pick_position(input longint unsigned lim);
        int unsigned span;
        span = (lim < 128) ? 32'(lim) : 32'd128;
        if (span == 0 || $urandom_range(6) == 0)
            return LIDX_W'($urandom);
        if ($urandom_range(5) == 0)
            return LIDX_W'(lim - 1 - $urandom_range(span - 1));
        return LIDX_W'($urandom_range(span - 1));
    endfunction

    function automatic logic [LOGIT_W-1:0] random_logit();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($urandom_range(131071)) - 32'd65536;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                             input logic [TOKEN_W-1:0] token, input logic [LIDX_W-1:0] lidx,
                             input logic [LOGIT_W-1:0] logit);
        result_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {logit, lidx, token, slot};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (update_penalty_model(op, slot, token, lidx, logit, res))
            expected_logits.push_back(res);
    endtask

    // Drops the input and waits until every result is out and any clear sweep is done.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_logits.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_PENALTY_GAIN: penalty_gain_q = value[GAIN_W-1:0];
            REG_INVERSE_GAIN: inverse_gain_q = value[GAIN_W-1:0];
            REG_SHARD_OFFSET: shard_offset_q = value[TOKEN_W-1:0];
            REG_SHARD_SIZE:   shard_size_q = value[SIZE_W-1:0];
            REG_SHARDED_MODE: sharded_mode_q = value[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [GAIN_W-1:0] pgain, input logic [GAIN_W-1:0] igain,
                                  input logic [TOKEN_W-1:0] offset, input logic [SIZE_W-1:0] size,
                                  input logic mode);
        wait_idle();
        write_register(REG_PENALTY_GAIN, CFG_DATA_W'(pgain));
        write_register(REG_INVERSE_GAIN, CFG_DATA_W'(igain));
        write_register(REG_SHARD_OFFSET, CFG_DATA_W'(offset));
        write_register(REG_SHARD_SIZE, CFG_DATA_W'(size));
        write_register(REG_SHARDED_MODE, CFG_DATA_W'(mode));
        cfg_valid <= 1'b0;
    endtask

    // Mostly marks and penalties on a few slots inside the active window, with rare
    // clears, some out-of-window ids and a sprinkling of ignored beats.
    task automatic run_random_items(input int count);
        int                 sent;
        int                 r;
        logic [SLOT_W-1:0]  slot;
        logic [TOKEN_W-1:0] token;
        logic [LIDX_W-1:0]  pos;
        longint unsigned    lim;
        sent = 0;
        lim = slice_limit();
        while (sent < count)
        begin
            r = $urandom_range(99);
            slot = ($urandom_range(3) != 0) ? SLOT_W'($urandom_range(3))
                                            : SLOT_W'($urandom_range(15));
            pos = pick_position(lim);
            if (r < 3)
            begin
                send_item(OP_CLEAR, slot, TOKEN_W'($urandom), LIDX_W'($urandom), $urandom);
            end
            else if (r < 40)
            begin
                if ($urandom_range(9) == 0)
                    token = TOKEN_W'($urandom);
                else if (sharded_mode_q)
                    token = TOKEN_W'(shard_offset_q + pos);
                else
                    token = TOKEN_W'(pos);
                send_item(OP_MARK, slot, token, LIDX_W'($urandom), $urandom);
            end
            else if (r < 97)
            begin
                send_item(OP_PENALIZE, slot, TOKEN_W'($urandom), pos, random_logit());
            end
            else
            begin
                send_item(OP_UNUSED, slot, TOKEN_W'($urandom), pos, $urandom);
            end
            if (r < 97)
                sent++;
        end
    endtask

    task automatic test_default_marks();
        send_item(OP_MARK, 4'd0, 20'd0, 16'd0, 32'd0);
        send_item(OP_MARK, 4'd0, 20'd65535, 16'd0, 32'd0);
        send_item(OP_MARK, 4'd15, 20'hFFFFF, 16'd0, 32'd0);
        send_item(OP_MARK, 4'd15, 20'd777, 16'd0, 32'd0);
        send_item(OP_PENALIZE, 4'd0, 20'd0, 16'd0, 32'h8000_0000);
        send_item(OP_PENALIZE, 4'd0, 20'd0, 16'hFFFF, 32'h7FFF_FFFF);
        send_item(OP_PENALIZE, 4'd15, 20'd0, 16'd777, 32'hFFFF_FFFF);
        send_item(OP_PENALIZE, 4'd1, 20'd0, 16'd777, 32'h0001_2345);
        send_item(OP_UNUSED, 4'd0, 20'hFFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_CLEAR, 4'd0, 20'd0, 16'd0, 32'd0);
        send_item(OP_PENALIZE, 4'd0, 20'd0, 16'd0, 32'd5);
    endtask

    task automatic test_gain_extremes();
        apply_settings(16'hFFFF, 16'h0000, 20'd0, 17'd65536, 1'b0);
        send_item(OP_PENALIZE, 4'd15, 20'd0, 16'd777, 32'h8000_0000);
        send_item(OP_PENALIZE, 4'd15, 20'd0, 16'd777, 32'h7FFF_FFFF);
        apply_settings(16'h0000, 16'hFFFF, 20'd0, 17'd65536, 1'b0);
        send_item(OP_PENALIZE, 4'd15, 20'd0, 16'd777, 32'h7FFF_FFFF);
        send_item(OP_PENALIZE, 4'd15, 20'd0, 16'd777, -32'sd5);
        // A gain of one half puts odd inputs exactly on a rounding tie.
        apply_settings(16'd2048, 16'd2048, 20'd0, 17'd65536, 1'b0);
        send_item(OP_PENALIZE, 4'd15, 20'd0, 16'd777, 32'd3);
        send_item(OP_PENALIZE, 4'd15, 20'd0, 16'd777, -32'sd3);
    endtask

    task automatic test_shard_window();
        apply_settings(16'd8192, 16'd2048, 20'd1000, 17'd100, 1'b1);
        send_item(OP_MARK, 4'd2, 20'd999, 16'd0, 32'd0);
        send_item(OP_MARK, 4'd2, 20'd1000, 16'd0, 32'd0);
        send_item(OP_MARK, 4'd2, 20'd1099, 16'd0, 32'd0);
        send_item(OP_MARK, 4'd2, 20'd1100, 16'd0, 32'd0);
        send_item(OP_PENALIZE, 4'd2, 20'd0, 16'd0, -32'sh10000);
        send_item(OP_PENALIZE, 4'd2, 20'd0, 16'd99, 32'h0003_0000);
        send_item(OP_PENALIZE, 4'd2, 20'd0, 16'd100, 32'h0003_0000);
        // Offset at the top of the id range: the window runs past 20 bits.
        apply_settings(16'd4096, 16'd4096, 20'hFFFFF, 17'd65536, 1'b1);
        send_item(OP_MARK, 4'd3, 20'hFFFFF, 16'd0, 32'd0);
        send_item(OP_PENALIZE, 4'd3, 20'd0, 16'd0, 32'd7);
        // With a zero size nothing is in range, not even a position already marked.
        apply_settings(16'd4096, 16'd4096, 20'hFFFFF, 17'd0, 1'b1);
        send_item(OP_PENALIZE, 4'd3, 20'd0, 16'd0, 32'd7);
    endtask

    task automatic test_random_unsharded();
        send_idle_pct = 19;
        recv_idle_pct = 69;
        apply_settings(GAIN_W'($urandom), GAIN_W'($urandom), TOKEN_W'($urandom),
                       17'h1FFFF, 1'b0);
        run_random_items(200);
    endtask

    task automatic test_random_sharded();
        send_idle_pct = 69;
        recv_idle_pct = 19;
        apply_settings(GAIN_W'($urandom), GAIN_W'($urandom), TOKEN_W'($urandom),
                       SIZE_W'($urandom_range(65536, 1)), 1'b1);
        run_random_items(100);
        apply_settings(GAIN_W'($urandom), GAIN_W'($urandom), 20'hFFFF0, 17'd65536, 1'b1);
        run_random_items(100);
    endtask

    task automatic test_random_back_to_back();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_settings(16'hFFFF, 16'hFFFF, 20'd0, 17'd1, 1'b1);
        run_random_items(50);
        apply_settings(GAIN_W'($urandom), GAIN_W'($urandom), 20'd0, 17'd300, 1'b0);
        run_random_items(150);
    endtask

    // The receiver holds off long enough for the output queue and pipeline to fill,
    // so the input side has to stall.
    task automatic test_output_stall();
        stall_request = 400;
        for (int i = 0; i < 40; i++)
            send_item(OP_PENALIZE, SLOT_W'($urandom_range(3)), 20'd0,
                      pick_position(slice_limit()), random_logit());
    endtask

    // Result checker.
    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (expected_logits.size() == 0)
                begin
                    $error("result beat with no penalize item pending: logit_out %0d",
                           $signed(m_axis_tdata));
                    error_count++;
                end
                else
                begin
                    want = expected_logits.pop_front();
                    if (m_axis_tdata !== want.logit_out)
                    begin
                        $error("logit_out: expected %0d, got %0d", want.logit_out,
                               $signed(m_axis_tdata));
                        error_count++;
                    end
                    if (m_axis_tuser[0] !== want.was_penalized)
                    begin
                        $error("was_penalized: expected %0b, got %0b", want.was_penalized,
                               m_axis_tuser[0]);
                        error_count++;
                    end
                    if (m_axis_tuser[1] !== want.saturated)
                    begin
                        $error("saturated: expected %0b, got %0b", want.saturated,
                               m_axis_tuser[1]);
                        error_count++;
                    end
                end
            end
        end
    end

    // Result side: random hold-offs, plus one long stall on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_request > 0)
            begin
                stall_left = stall_request;
                stall_request = 0;
            end
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        send_idle_pct = 19;
        recv_idle_pct = 69;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_default_marks();
        test_gain_extremes();
        test_shard_window();
        test_random_unsharded();
        test_random_sharded();
        test_random_back_to_back();
        test_output_stall();
        wait_idle();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
